>>> rtl/dfos_pkg.sv
`default_nettype none
package dfos_pkg;

    localparam int DEPTH_W  = 16;
    localparam int COL_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DFOS_FRAME_WIDTH = 640;

    localparam logic [DEPTH_W-1:0] OBST_DIST_RST = 16'd500;
    localparam logic [COL_W-1:0]   CENTRE_COL_RST = 10'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBST_DIST  = 2'd0,
        CFG_CENTRE_COL = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_LEFT    = 2'd2,
        ACT_RIGHT   = 2'd3
    } t_action;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]   column;
        logic               frame_end;
    } t_pixel;

    typedef struct packed {
        logic [DEPTH_W-1:0] obst_dist;
        logic [COL_W-1:0]   centre_col;
    } t_cfg;

    typedef struct packed {
        t_action            action;
        logic [DEPTH_W-1:0] nearest_depth;
        logic [COL_W-1:0]   deepest_column;
    } t_result;

    function automatic t_action steer_next(
        input t_action            cur,
        input logic [DEPTH_W-1:0] nearest,
        input logic [COL_W-1:0]   deep_col,
        input t_cfg               cfg
    );
        logic    blocked;
        t_action nxt;
        blocked = (nearest <= cfg.obst_dist);
        case (cur)
            ACT_FORWARD: nxt = blocked ? ACT_STOP : ACT_FORWARD;
            ACT_STOP: begin
                if (!blocked) begin
                    nxt = ACT_FORWARD;
                end else begin
                    nxt = (deep_col > cfg.centre_col) ? ACT_LEFT : ACT_RIGHT;
                end
            end
            ACT_LEFT:    nxt = blocked ? ACT_LEFT : ACT_STOP;
            ACT_RIGHT:   nxt = blocked ? ACT_RIGHT : ACT_STOP;
            default:     nxt = ACT_STOP;
        endcase
        return nxt;
    endfunction

endpackage
`default_nettype wire

>>> rtl/dfos_if.sv
`default_nettype none
interface dfos_pix_if;
    import dfos_pkg::*;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth;
    logic [COL_W-1:0]   column;
    logic               frame_end;
    modport source (output valid, output depth, output column, output frame_end, input ready);
    modport sink   (input valid, input depth, input column, input frame_end, output ready);
endinterface

interface dfos_res_if;
    import dfos_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [DEPTH_W-1:0] nearest_depth;
    logic [COL_W-1:0]   deepest_column;
    modport source (output valid, output action, output nearest_depth,
                    output deepest_column, input ready);
    modport sink   (input valid, input action, input nearest_depth,
                    input deepest_column, output ready);
endinterface

interface dfos_cfg_if;
    import dfos_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/dfos_in_reg.sv
`default_nettype none
module dfos_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire dfos_pkg::t_pixel i_pix,
    output logic                 o_valid,
    output dfos_pkg::t_pixel     o_pix,
    input  wire logic            i_take
);
    import dfos_pkg::*;

    logic   r_valid;
    t_pixel r_pix;

    // load a new word whenever the held one leaves or none is held
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_pix   = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= i_pix;
        end
    end

endmodule
`default_nettype wire

>>> rtl/dfos_core.sv
`default_nettype none
module dfos_core #(
    parameter int FRAME_WIDTH = dfos_pkg::DFOS_FRAME_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dfos_pkg::t_cfg   i_cfg,
    input  wire logic             i_valid,
    input  wire dfos_pkg::t_pixel i_pix,
    output logic                  o_take,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dfos_pkg::t_result     o_result
);
    import dfos_pkg::*;

    localparam logic [COL_W:0]   WIDTH_EXT = (COL_W+1)'(FRAME_WIDTH);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(FRAME_WIDTH - 1);

    logic               r_frame_open;
    logic               r_any;
    logic [DEPTH_W-1:0] r_near;
    logic [DEPTH_W-1:0] r_deep;
    logic [COL_W-1:0]   r_dcol;
    t_action            r_mode;
    logic               r_out_valid;
    t_result            r_result;

    logic [COL_W-1:0]   col_sat;
    logic               deep_upd;
    logic               near_upd;
    logic               n_any;
    logic [DEPTH_W-1:0] n_near;
    logic [DEPTH_W-1:0] n_deep;
    logic [COL_W-1:0]   n_dcol;
    logic [DEPTH_W-1:0] frame_near;
    t_action            n_mode;
    logic               out_free;
    logic               emit;

    assign out_free = !r_out_valid || i_ready;
    // a frame-end word needs room in the result register; others never stall
    assign o_take   = i_valid && (!i_pix.frame_end || out_free);
    assign emit     = o_take && i_pix.frame_end;

    always_comb begin
        col_sat  = ({1'b0, i_pix.column} >= WIDTH_EXT) ? LAST_COL : i_pix.column;
        deep_upd = !r_frame_open || (i_pix.depth > r_deep);
        near_upd = (i_pix.depth != '0) && (!r_any || (i_pix.depth < r_near));
        n_deep   = deep_upd ? i_pix.depth : r_deep;
        n_dcol   = deep_upd ? col_sat : r_dcol;
        n_near   = near_upd ? i_pix.depth : r_near;
        n_any    = r_any || near_upd;
        frame_near = n_any ? n_near : '0;
        n_mode   = steer_next(r_mode, frame_near, n_dcol, i_cfg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_any        <= 1'b0;
            r_near       <= '0;
            r_deep       <= '0;
            r_dcol       <= '0;
            r_mode       <= ACT_FORWARD;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                if (i_pix.frame_end) begin
                    // clear the accumulators for the next frame
                    r_frame_open <= 1'b0;
                    r_any        <= 1'b0;
                    r_near       <= '0;
                    r_deep       <= '0;
                    r_dcol       <= '0;
                    r_mode       <= n_mode;
                end else begin
                    r_frame_open <= 1'b1;
                    r_any        <= n_any;
                    r_near       <= n_near;
                    r_deep       <= n_deep;
                    r_dcol       <= n_dcol;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result.action         <= n_mode;
            r_result.nearest_depth  <= frame_near;
            r_result.deepest_column <= n_dcol;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> rtl/depth_frame_obstacle_steering.sv
`default_nettype none
// A frame-end word passes through the input register, then the statistics
// and steering result register, which gives its result.
// Throughput: one pixel word per cycle, except while a frame-end word waits;
// it waits only while the result register holds an untaken result.
// Reset (synchronous, active low): mode forward, frame statistics cleared,
// obstacle distance 500 and centre column 320.
module depth_frame_obstacle_steering #(
    parameter int FRAME_WIDTH = dfos_pkg::DFOS_FRAME_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dfos_pix_if.sink    i_pix,
    dfos_cfg_if.sink    i_cfg,
    dfos_res_if.source  o_res
);
    import dfos_pkg::*;

    t_cfg    r_cfg;
    t_pixel  in_pix;
    t_pixel  held_pix;
    logic    held_valid;
    logic    core_take;
    t_result result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obst_dist  <= OBST_DIST_RST;
            r_cfg.centre_col <= CENTRE_COL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OBST_DIST:  r_cfg.obst_dist  <= i_cfg.data;
                CFG_CENTRE_COL: r_cfg.centre_col <= i_cfg.data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_pix.depth     = i_pix.depth;
    assign in_pix.column    = i_pix.column;
    assign in_pix.frame_end = i_pix.frame_end;

    dfos_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_pix   (in_pix),
        .o_valid (held_valid),
        .o_pix   (held_pix),
        .i_take  (core_take)
    );

    dfos_core #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (held_valid),
        .i_pix    (held_pix),
        .o_take   (core_take),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (result)
    );

    assign o_res.action         = result.action;
    assign o_res.nearest_depth  = result.nearest_depth;
    assign o_res.deepest_column = result.deepest_column;

endmodule
`default_nettype wire
